// ===== hw/rtl/slc_pkg.sv =====
`timescale 1ns / 1ps

package slc_pkg;

    // Level format: unsigned, LVL_FRAC fraction bits, one integer bit for 1.0
    localparam int LVL_FRAC = 10;
    localparam int LVL_W    = LVL_FRAC + 1;
    // Wide enough for 1275 * level and 765 * 2^LVL_FRAC
    localparam int CALC_W   = LVL_W + 12;
    localparam int COLOR_W  = 8;

    localparam logic [CALC_W-1:0] ONE_Q = CALC_W'(1) << LVL_FRAC;

    // Display style codes
    localparam logic [1:0] STYLE_MULTI = 2'd0;
    localparam logic [1:0] STYLE_BW    = 2'd1;
    localparam logic [1:0] STYLE_BLUE  = 2'd2;

    typedef logic [COLOR_W-1:0] t_color;

    // Gauge color stops: row is the stop, column is red, green, blue
    localparam t_color GAUGE_STOPS [3][3] = '{
        '{8'd35,  8'd110, 8'd220},
        '{8'd45,  8'd210, 8'd75},
        '{8'd220, 8'd55,  8'd45}
    };

    // Reciprocal of 20 in Q0.16; exact floor for numerators up to 1785
    localparam int RECIP_SHIFT = 16;
    localparam logic [22:0] RECIP_20 = 23'd3277;

    // Lift a component by 35% of its distance to full scale
    function automatic t_color lift_comp(input t_color c);
        logic [10:0] gap7;
        logic [22:0] prod;
        gap7 = 11'(8'd255 - c) * 11'd7;
        prod = 23'(gap7) * RECIP_20;
        return c + {1'b0, prod[22:RECIP_SHIFT]};
    endfunction

    // Interpolate between two stops; amt runs from 0 to ONE_Q
    function automatic t_color gauge_mix(input t_color from_c, input t_color to_c,
                                         input logic [CALC_W-1:0] amt);
        logic [CALC_W-1:0] base;
        logic [CALC_W-1:0] acc;
        base = CALC_W'(from_c) << LVL_FRAC;
        if (to_c >= from_c) begin
            acc = base + CALC_W'(to_c - from_c) * amt;
        end else begin
            acc = base - CALC_W'(from_c - to_c) * amt;
        end
        acc = acc >> LVL_FRAC;
        return acc[COLOR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/signal_level_colormap.sv =====
`timescale 1ns / 1ps

// Signal level to color mapper.
//
// Input channel (i_in_valid / o_in_ready) carries one signal level per beat,
// unsigned with slc_pkg::LVL_FRAC fraction bits; 1.0 is the largest legal
// value and anything above saturates to it. Each beat yields exactly one
// output beat (o_out_valid / i_out_ready) holding three RGB colors: the
// display color in the configured style, the trace color (display lifted
// toward white) and the gauge color.
//
// Configuration: a 2-bit display style written on i_cfg_valid / o_cfg_ready
// (always ready). Write it only while no beat is in flight.
//
// Path: one input register that captures each accepted level, one pass of
// constant-coefficient arithmetic, one output register holding o_out_valid.
// Throughput is one beat per cycle unless the receiver stalls. When it
// stalls, the output register holds its beat and the input register still
// takes one more beat; after that o_in_ready follows i_out_ready.
//
// Synchronous active-low reset empties both registers and sets the style to
// multicolor.
module signal_level_colormap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [slc_pkg::LVL_W-1:0]   i_level,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [slc_pkg::COLOR_W-1:0] o_display_red,
    output logic [slc_pkg::COLOR_W-1:0] o_display_green,
    output logic [slc_pkg::COLOR_W-1:0] o_display_blue,
    output logic [slc_pkg::COLOR_W-1:0] o_trace_red,
    output logic [slc_pkg::COLOR_W-1:0] o_trace_green,
    output logic [slc_pkg::COLOR_W-1:0] o_trace_blue,
    output logic [slc_pkg::COLOR_W-1:0] o_gauge_red,
    output logic [slc_pkg::COLOR_W-1:0] o_gauge_green,
    output logic [slc_pkg::COLOR_W-1:0] o_gauge_blue
);

    localparam int LW  = slc_pkg::LVL_W;
    localparam int CW  = slc_pkg::CALC_W;
    localparam int FB  = slc_pkg::LVL_FRAC;
    localparam logic [CW-1:0] ONE = slc_pkg::ONE_Q;

    // Control and payload registers
    logic [1:0]           r_style;
    logic                 r_s1_valid, n_s1_valid;
    logic [LW-1:0]        r_level;
    logic                 r_out_valid, n_out_valid;
    slc_pkg::t_color      r_disp  [3];
    slc_pkg::t_color      r_trace [3];
    slc_pkg::t_color      r_gauge [3];

    logic                 out_load;
    logic [CW-1:0]        lv;
    logic [CW-1:0]        t_red, t_green, t_blue;
    logic [CW-1:0]        grey;
    logic [CW-1:0]        amt;
    logic                 seg_hi;
    slc_pkg::t_color      disp  [3];
    slc_pkg::t_color      trace [3];
    slc_pkg::t_color      gauge [3];

    // Handshake: the output register loads when empty or being drained
    assign o_cfg_ready = 1'b1;
    assign out_load    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || out_load;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_in_ready) begin
            n_s1_valid = i_in_valid;
        end
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style     <= slc_pkg::STYLE_MULTI;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_style <= i_cfg_data;
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the level with each accepted beat
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_level <= i_level;
        end
    end

    // Saturate above 1.0
    assign lv   = (CW'(r_level) > ONE) ? ONE : CW'(r_level);
    assign grey = (lv * CW'(255)) >> FB;

    // Display color
    always_comb begin
        t_red   = '0;
        t_green = '0;
        t_blue  = '0;
        unique case (r_style)
            slc_pkg::STYLE_MULTI: begin
                // Blue rises to 0.2, falls to zero at 0.7
                if (lv * CW'(5) <= ONE) begin
                    t_blue = (lv * CW'(1275)) >> FB;
                end else if (lv * CW'(10) <= ONE * CW'(7)) begin
                    t_blue = (ONE * CW'(357) - lv * CW'(510)) >> FB;
                end
                // Green rises from 0.2 to 0.6, falls to zero at 0.9
                if ((lv * CW'(5) >= ONE) && (lv * CW'(5) <= ONE * CW'(3))) begin
                    t_green = (lv * CW'(1275) - ONE * CW'(255)) >> (FB + 1);
                end else if ((lv * CW'(5) > ONE * CW'(3))
                             && (lv * CW'(10) <= ONE * CW'(9))) begin
                    t_green = (ONE * CW'(765) - lv * CW'(850)) >> FB;
                end
                // Red rises from 0.5
                if (lv * CW'(2) >= ONE) begin
                    t_red = (lv * CW'(510) - ONE * CW'(255)) >> FB;
                end
            end
            slc_pkg::STYLE_BW: begin
                t_red   = grey;
                t_green = grey;
                t_blue  = grey;
            end
            slc_pkg::STYLE_BLUE: begin
                t_red   = grey;
                t_green = grey;
                t_blue  = (grey < CW'(127)) ? (grey << 1) : CW'(255);
            end
            default: begin
                // Unused style code: black
                t_red   = '0;
                t_green = '0;
                t_blue  = '0;
            end
        endcase
    end

    assign disp[0] = t_red[slc_pkg::COLOR_W-1:0];
    assign disp[1] = t_green[slc_pkg::COLOR_W-1:0];
    assign disp[2] = t_blue[slc_pkg::COLOR_W-1:0];

    // Gauge segment: first half up to and including 0.5
    assign seg_hi = (lv * CW'(2) > ONE);
    assign amt    = seg_hi ? (lv * CW'(2) - ONE) : (lv * CW'(2));

    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign trace[k] = slc_pkg::lift_comp(disp[k]);
        always_comb begin
            if (r_style != slc_pkg::STYLE_MULTI) begin
                gauge[k] = trace[k];
            end else if (seg_hi) begin
                gauge[k] = slc_pkg::gauge_mix(slc_pkg::GAUGE_STOPS[1][k],
                                              slc_pkg::GAUGE_STOPS[2][k], amt);
            end else begin
                gauge[k] = slc_pkg::gauge_mix(slc_pkg::GAUGE_STOPS[0][k],
                                              slc_pkg::GAUGE_STOPS[1][k], amt);
            end
        end

        // Hold the result while the receiver stalls
        always_ff @(posedge i_clk) begin
            if (out_load) begin
                r_disp[k]  <= disp[k];
                r_trace[k] <= trace[k];
                r_gauge[k] <= gauge[k];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_display_red   = r_disp[0];
    assign o_display_green = r_disp[1];
    assign o_display_blue  = r_disp[2];
    assign o_trace_red     = r_trace[0];
    assign o_trace_green   = r_trace[1];
    assign o_trace_blue    = r_trace[2];
    assign o_gauge_red     = r_gauge[0];
    assign o_gauge_green   = r_gauge[1];
    assign o_gauge_blue    = r_gauge[2];

endmodule

// ===== hw/rtl/slc_checker.sv =====
`timescale 1ns / 1ps

module slc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [slc_pkg::COLOR_W-1:0] o_display_red,
    input logic [slc_pkg::COLOR_W-1:0] o_display_green,
    input logic [slc_pkg::COLOR_W-1:0] o_display_blue,
    input logic [slc_pkg::COLOR_W-1:0] o_trace_red,
    input logic [slc_pkg::COLOR_W-1:0] o_trace_green,
    input logic [slc_pkg::COLOR_W-1:0] o_trace_blue,
    input logic [slc_pkg::COLOR_W-1:0] o_gauge_red,
    input logic [slc_pkg::COLOR_W-1:0] o_gauge_green,
    input logic [slc_pkg::COLOR_W-1:0] o_gauge_blue
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Stalled beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // Stalled beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_display_red) && $stable(o_display_green) && $stable(o_display_blue)
            && $stable(o_trace_red) && $stable(o_trace_green) && $stable(o_trace_blue)
            && $stable(o_gauge_red) && $stable(o_gauge_green) && $stable(o_gauge_blue))
        else $error("output payload changed while stalled");

    // Trace color is never darker than the display color, and trace red is at least the lift of black
    a_trace_lift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_trace_red >= o_display_red) && (o_trace_green >= o_display_green)
            && (o_trace_blue >= o_display_blue) && (o_trace_red >= 8'd89))
        else $error("trace color below display color");

endmodule

bind signal_level_colormap slc_checker u_slc_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // Clock and run limits
    localparam int  CLK_HALF      = 4;
    localparam int  RESET_CYCLES  = 8;
    localparam int  TAIL_CYCLES   = 12;
    localparam int  MAX_REPORTS   = 100;
    localparam int  RUN_LIMIT_NS  = 5_000_000;

    // Level scale: FULL_SCALE is 1.0, LEVEL_MAX is the largest value the port carries
    localparam int  FULL_SCALE    = 1 << slc_pkg::LVL_FRAC;
    localparam int  LEVEL_MAX     = (1 << slc_pkg::LVL_W) - 1;

    // The fourth style code has no ramp of its own and paints black
    localparam logic [1:0] STYLE_UNUSED = 2'd3;

    // Color groups carried by one output beat
    localparam int  GRP_DISPLAY   = 0;
    localparam int  GRP_TRACE     = 1;
    localparam int  GRP_GAUGE     = 2;

    // Index by [group][component], component 0 red, 1 green, 2 blue
    typedef slc_pkg::t_color [2:0][2:0] t_pixel_colors;

    // Directed part: ramp breakpoints, saturation, the blue-tint knee, unused style
    localparam int N_DIRECTED = 23;
    localparam logic [1:0] DIR_STYLE [N_DIRECTED] = '{
        slc_pkg::STYLE_MULTI, slc_pkg::STYLE_MULTI, slc_pkg::STYLE_MULTI,
        slc_pkg::STYLE_MULTI, slc_pkg::STYLE_MULTI, slc_pkg::STYLE_MULTI,
        slc_pkg::STYLE_MULTI, slc_pkg::STYLE_MULTI, slc_pkg::STYLE_MULTI,
        slc_pkg::STYLE_MULTI, slc_pkg::STYLE_MULTI, slc_pkg::STYLE_MULTI,
        slc_pkg::STYLE_MULTI, slc_pkg::STYLE_MULTI,
        slc_pkg::STYLE_BW, slc_pkg::STYLE_BW, slc_pkg::STYLE_BW,
        slc_pkg::STYLE_BLUE, slc_pkg::STYLE_BLUE, slc_pkg::STYLE_BLUE,
        STYLE_UNUSED, STYLE_UNUSED, STYLE_UNUSED
    };
    localparam int DIR_LEVEL [N_DIRECTED] = '{
        0, 204, 205, 512, 513, 614, 615, 716, 717, 921, 922, 1024, 1025, LEVEL_MAX,
        0, FULL_SCALE, LEVEL_MAX,
        509, 510, LEVEL_MAX,
        0, 700, LEVEL_MAX
    };

    // Levels around the ramp corners, used to bias part of the random stimulus
    localparam int N_BREAKS = 7;
    localparam int BREAK_LEVELS [N_BREAKS] = '{205, 510, 512, 614, 717, 922, 1024};

    // Idle phases: sender idle and receiver stall, in percent
    localparam int N_IDLE_PHASES = 4;
    localparam int SEND_IDLE  [N_IDLE_PHASES] = '{0, 67, 0, 19};
    localparam int RECV_STALL [N_IDLE_PHASES] = '{0, 0, 67, 19};
    localparam int BURST_ITEMS = 56;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         cfg_valid   = 1'b0;
    logic [1:0]                   cfg_data    = slc_pkg::STYLE_MULTI;
    logic                         in_valid    = 1'b0;
    logic [slc_pkg::LVL_W-1:0]    in_level    = '0;
    logic                         out_ready   = 1'b0;
    logic                         cfg_ready;
    logic                         in_ready;
    logic                         out_valid;
    slc_pkg::t_color              display_red, display_green, display_blue;
    slc_pkg::t_color              trace_red, trace_green, trace_blue;
    slc_pkg::t_color              gauge_red, gauge_green, gauge_blue;

    // Style the block holds, mirrored on every accepted config beat
    logic [1:0]                   style_setting = slc_pkg::STYLE_MULTI;
    int                           send_idle_pct = 0;
    int                           recv_stall_pct = 0;
    int                           error_count = 0;

    logic [slc_pkg::LVL_W-1:0]    pending_levels [$];
    t_pixel_colors                expected_pixels [$];

    string group_name [3] = '{"display", "trace", "gauge"};
    string comp_name  [3] = '{"red", "green", "blue"};

    signal_level_colormap u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_level         (in_level),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_display_red   (display_red),
        .o_display_green (display_green),
        .o_display_blue  (display_blue),
        .o_trace_red     (trace_red),
        .o_trace_green   (trace_green),
        .o_trace_blue    (trace_blue),
        .o_gauge_red     (gauge_red),
        .o_gauge_green   (gauge_green),
        .o_gauge_blue    (gauge_blue)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Map one level to its three colors under the given style, in exact integers
    function automatic t_pixel_colors map_level(input logic [slc_pkg::LVL_W-1:0] level,
                                                input logic [1:0] style);
        t_pixel_colors px;
        int lv, r, g, b, lifted, k, seg, amt, from_c, to_c;
        int disp [3];
        // saturate anything above 1.0
        lv = (int'(level) > FULL_SCALE) ? FULL_SCALE : int'(level);
        r = 0;
        g = 0;
        b = 0;
        case (style)
            slc_pkg::STYLE_MULTI: begin
                // blue: rise to 0.2, fall to zero at 0.7; the corner belongs to the rise
                if (5 * lv <= FULL_SCALE) begin
                    b = 1275 * lv / FULL_SCALE;
                end else if (10 * lv <= 7 * FULL_SCALE) begin
                    b = (357 * FULL_SCALE - 510 * lv) / FULL_SCALE;
                end
                // green: rise from 0.2 to 0.6, fall to zero at 0.9
                if (5 * lv >= FULL_SCALE && 5 * lv <= 3 * FULL_SCALE) begin
                    g = (1275 * lv - 255 * FULL_SCALE) / (2 * FULL_SCALE);
                end else if (5 * lv > 3 * FULL_SCALE && 10 * lv <= 9 * FULL_SCALE) begin
                    g = (765 * FULL_SCALE - 850 * lv) / FULL_SCALE;
                end
                // red: rise from 0.5 to full
                if (2 * lv >= FULL_SCALE) begin
                    r = (510 * lv - 255 * FULL_SCALE) / FULL_SCALE;
                end
            end
            slc_pkg::STYLE_BW: begin
                r = 255 * lv / FULL_SCALE;
                g = r;
                b = r;
            end
            slc_pkg::STYLE_BLUE: begin
                r = 255 * lv / FULL_SCALE;
                g = r;
                b = (r < 127) ? 2 * r : 255;
            end
            default: begin
            end
        endcase
        disp[0] = r;
        disp[1] = g;
        disp[2] = b;
        // gauge: two linear segments, the midpoint belongs to the first at full amount
        seg = (2 * lv <= FULL_SCALE) ? 0 : 1;
        amt = (seg == 0) ? 2 * lv : 2 * lv - FULL_SCALE;
        for (k = 0; k < 3; k++) begin
            lifted = disp[k] + (255 - disp[k]) * 7 / 20;
            px[GRP_DISPLAY][k] = slc_pkg::t_color'(disp[k]);
            px[GRP_TRACE][k]   = slc_pkg::t_color'(lifted);
            if (style == slc_pkg::STYLE_MULTI) begin
                from_c = int'(slc_pkg::GAUGE_STOPS[seg][k]);
                to_c   = int'(slc_pkg::GAUGE_STOPS[seg + 1][k]);
                px[GRP_GAUGE][k] = slc_pkg::t_color'(
                    (from_c * FULL_SCALE + (to_c - from_c) * amt) / FULL_SCALE);
            end else begin
                px[GRP_GAUGE][k] = slc_pkg::t_color'(lifted);
            end
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $time, what);
        end
        error_count++;
    endtask

    // Drive the input channel from the pending queue; predict each accepted beat
    always @(posedge i_clk) begin
        logic busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                expected_pixels.push_back(map_level(in_level, style_setting));
            end
            // hold valid and payload until the beat goes through
            busy = in_valid && !in_ready;
            if (!busy) begin
                if (pending_levels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_level <= pending_levels.pop_front();
                end else begin
                    // drop valid and scramble the idle payload
                    in_valid <= 1'b0;
                    in_level <= slc_pkg::LVL_W'($urandom_range(LEVEL_MAX));
                end
            end
        end
    end

    // Check every output beat against the oldest prediction; throttle ready
    always @(posedge i_clk) begin
        t_pixel_colors got, want;
        int grp, k;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                got[GRP_DISPLAY] = {display_blue, display_green, display_red};
                got[GRP_TRACE]   = {trace_blue, trace_green, trace_red};
                got[GRP_GAUGE]   = {gauge_blue, gauge_green, gauge_red};
                if (expected_pixels.size() == 0) begin
                    report_mismatch("output beat with no beat expected");
                end else begin
                    want = expected_pixels.pop_front();
                    for (grp = 0; grp < 3; grp++) begin
                        for (k = 0; k < 3; k++) begin
                            if (got[grp][k] !== want[grp][k]) begin
                                report_mismatch($sformatf("%s_%s got %0d expected %0d",
                                    group_name[grp], comp_name[k], got[grp][k],
                                    want[grp][k]));
                            end
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Advance to the falling edge where nothing is queued, in flight or expected
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_levels.size() != 0 || in_valid || expected_pixels.size() != 0);
    endtask

    // Write the style register; only called with the pipeline empty
    task automatic write_style(input logic [1:0] style);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= style;
        do begin
            @(posedge i_clk);
        end while (!cfg_ready);
        cfg_valid     <= 1'b0;
        style_setting = style;
    endtask

    initial begin
        int i, p, s, n, sel;
        logic [1:0] style;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats; rewrite the style whenever the table moves to a new one
        for (i = 0; i < N_DIRECTED; i++) begin
            if (i == 0 || DIR_STYLE[i] != DIR_STYLE[i - 1]) begin
                wait_drained();
                write_style(DIR_STYLE[i]);
            end
            pending_levels.push_back(slc_pkg::LVL_W'(DIR_LEVEL[i]));
        end
        wait_drained();

        // Random beats: every idle phase runs through every style code
        for (p = 0; p < N_IDLE_PHASES; p++) begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            for (s = 0; s < 4; s++) begin
                style = 2'((p + s) % 4);
                write_style(style);
                // two bursts; hold the sender off in between until all beats return
                for (n = 0; n < 2 * BURST_ITEMS; n++) begin
                    if (n == BURST_ITEMS) begin
                        wait_drained();
                    end
                    sel = $urandom_range(99);
                    if (sel < 70) begin
                        pending_levels.push_back(
                            slc_pkg::LVL_W'($urandom_range(FULL_SCALE)));
                    end else if (sel < 85) begin
                        pending_levels.push_back(slc_pkg::LVL_W'(
                            BREAK_LEVELS[$urandom_range(N_BREAKS - 1)]
                            + $urandom_range(4) - 2));
                    end else begin
                        pending_levels.push_back(
                            slc_pkg::LVL_W'($urandom_range(LEVEL_MAX)));
                    end
                end
                wait_drained();
            end
        end

        // Give any stray beat time to show up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d beats still expected", expected_pixels.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
